FILE: sv/spe_pkg.sv
`default_nettype none
package spe_pkg;
   localparam int DefMaxStops = 64;
   localparam int DefMaxEdges = 256;
   localparam logic [16:0] UNREACHED = 17'd99999;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   // one stored edge
   typedef struct packed {
      logic [9:0] line;
      logic [7:0] minutes;
      logic [5:0] to;
      logic [5:0] from;
   } edge_type;

   // saturating distance add used by relaxation
   function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [7:0] b);
      logic [17:0] s;
      s = {1'b0, a} + {10'd0, b};
      if (s > {1'b0, UNREACHED}) sat_add = UNREACHED;
      else sat_add = s[16:0];
   endfunction
endpackage
`default_nettype wire

FILE: sv/spe_edge_mem.sv
`default_nettype none
module spe_edge_mem
   import spe_pkg::*;
#(
   parameter int MAX_EDGES = DefMaxEdges,
   localparam int AW = $clog2(MAX_EDGES)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire edge_type      wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output edge_type           rd_data
);
   edge_type mem [MAX_EDGES];

   // write one edge, read one edge registered
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: sv/shortest_path_engine.sv
// channel | dir | tdata (low bit up)                                  | tuser
// req     | in  | req_type, edge_from, edge_to, edge_minutes, edge_line, | -
//         |     | query_start, query_dest (44 bits in 48)                |
// rsp     | out | path_stop, path_line (16 bits)                         | found; tlast=last
// A clear or an add is taken in the idle state; a query whose stops are out of range or
// equal answers not-found in the cycle after it is taken. Otherwise a query clears the
// per-stop store, then runs one round per reachable stop plus a last empty round: each
// round scans every stop to pick the nearest open stop, then reads every stored edge and
// relaxes those that leave it. The walk back stacks the hops; results go out start first.
// Synchronous reset clears edge_count and the sequencer; the stores need none.
// req_tready is low from a query until its last item is taken; rsp stalls hold it.
`default_nettype none
module shortest_path_engine
   import spe_pkg::*;
#(
   parameter int MAX_STOPS = DefMaxStops,
   parameter int MAX_EDGES = DefMaxEdges
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // req_type, edge_from, edge_to, edge_minutes,
                                        // edge_line, query_start, query_dest
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // path_stop, path_line
   output logic             rsp_tuser,  // found
   output logic             rsp_tlast
);
   localparam int AW = $clog2(MAX_EDGES);
   localparam int SW = $clog2(MAX_STOPS);
   localparam int CW = $clog2(MAX_EDGES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SEL, S_SCAN, S_FETCH, S_RELAX, S_WALK, S_HOP, S_EMIT, S_SEND,
      S_OUT
   } state_type;

   // request fields
   logic [1:0] f_type;
   edge_type   f_edge;
   logic [5:0] f_start, f_dest;
   assign f_type  = req_tdata[1:0];
   assign f_edge  = req_tdata[31:2];
   assign f_start = req_tdata[37:32];
   assign f_dest  = req_tdata[43:38];

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   // per-stop stores: {settled, distance}, predecessor {line, stop}, path stack
   logic [17:0] node_mem [MAX_STOPS];
   logic [15:0] pred_mem [MAX_STOPS];
   logic [15:0] stack_mem [MAX_STOPS];
   logic [17:0] node_rd_ff;
   logic [15:0] pred_rd_ff, stack_rd_ff;
   logic [SW-1:0] node_raddr, stack_raddr;
   logic [SW-1:0] start_ff, dest_ff, u_ff, best_ff;
   logic [SW:0] idx_ff;
   logic        have_ff, found_ff;
   logic [16:0] bd_ff, ud_ff;
   logic [CW-1:0] eidx_ff;
   logic [SW:0] n_ff, k_ff;
   logic [5:0]  cur_ff;

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // edge memory
   edge_type rd_edge;
   logic [AW-1:0] rd_addr;
   assign rd_addr = eidx_ff[AW-1:0];
   spe_edge_mem #(.MAX_EDGES(MAX_EDGES)) u_mem (
      .clock, .wr_en(accept && f_type == REQ_ADD && count_ff < CW'(MAX_EDGES)),
      .wr_addr(count_ff[AW-1:0]), .wr_data(f_edge), .rd_addr, .rd_data(rd_edge)
   );

   logic [16:0] relax_sum;
   logic [SW-1:0] to_idx;
   assign relax_sum = sat_add(ud_ff, rd_edge.minutes);
   assign to_idx = rd_edge.to[SW-1:0];

   // point the stop store at the edge target while fetching, else at the scan index
   always_comb begin
      case (state_ff)
         S_FETCH: node_raddr = to_idx;
         default: node_raddr = idx_ff[SW-1:0];
      endcase
   end
   assign stack_raddr = SW'(k_ff - 1'b1);

   // registered reads of the per-stop stores
   always_ff @(posedge clock) begin
      node_rd_ff  <= node_mem[node_raddr];
      pred_rd_ff  <= pred_mem[cur_ff[SW-1:0]];
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_tvalid <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (accept) begin
               case (f_type)
                  REQ_CLEAR: count_ff <= '0;
                  REQ_ADD: if (count_ff < CW'(MAX_EDGES)) count_ff <= count_ff + 1'b1;
                  REQ_QUERY: begin
                     if (32'(f_start) >= MAX_STOPS || 32'(f_dest) >= MAX_STOPS ||
                         f_start == f_dest) begin
                        rsp_tdata <= '0; rsp_tuser <= 1'b0; rsp_tlast <= 1'b1;
                        rsp_tvalid <= 1'b1; state_ff <= S_OUT;
                     end else begin
                        start_ff <= f_start[SW-1:0]; dest_ff <= f_dest[SW-1:0];
                        idx_ff <= '0; state_ff <= S_INIT;
                     end
                  end
                  default: ;
               endcase
            end
            S_INIT: begin
               // open every stop, the start at distance zero
               node_mem[idx_ff[SW-1:0]] <=
                  {1'b0, (idx_ff[SW-1:0] == start_ff) ? 17'd0 : UNREACHED};
               idx_ff <= idx_ff + 1'b1;
               if (32'(idx_ff) == MAX_STOPS - 1) begin
                  idx_ff <= '0; have_ff <= 1'b0; found_ff <= 1'b0;
                  bd_ff <= UNREACHED; state_ff <= S_SEL;
               end
            end
            S_SEL: begin
               logic          take;
               logic [SW-1:0] pick;
               // node_rd_ff holds the registered read of stop idx_ff - 1
               take = (idx_ff != '0) && !node_rd_ff[17] && node_rd_ff[16:0] < bd_ff;
               pick = take ? SW'(idx_ff - 1'b1) : best_ff;
               if (take) begin
                  bd_ff <= node_rd_ff[16:0]; best_ff <= pick; have_ff <= 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               if (32'(idx_ff) == MAX_STOPS) begin
                  idx_ff <= '0;
                  if (!(have_ff || take)) begin
                     if (!found_ff) begin
                        rsp_tdata <= '0; rsp_tuser <= 1'b0; rsp_tlast <= 1'b1;
                        rsp_tvalid <= 1'b1; state_ff <= S_OUT;
                     end else begin
                        stack_mem[0] <= {10'd0, 6'(dest_ff)};
                        cur_ff <= 6'(dest_ff); n_ff <= {{SW{1'b0}}, 1'b1};
                        state_ff <= S_WALK;
                     end
                  end else begin
                     // settle the picked stop and scan its edges
                     u_ff <= pick;
                     ud_ff <= take ? node_rd_ff[16:0] : bd_ff;
                     node_mem[pick] <= {1'b1, take ? node_rd_ff[16:0] : bd_ff};
                     if (pick == dest_ff) found_ff <= 1'b1;
                     eidx_ff <= '0; state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // the edge memory reads eidx_ff on this edge
               if (eidx_ff < count_ff) begin
                  state_ff <= S_FETCH;
               end else begin
                  have_ff <= 1'b0; bd_ff <= UNREACHED; state_ff <= S_SEL;
               end
            end
            S_FETCH: begin
               // skip edges that leave another stop or point past the last stop
               if (rd_edge.from == 6'(u_ff) && 32'(rd_edge.to) < MAX_STOPS) begin
                  state_ff <= S_RELAX;
               end else begin
                  eidx_ff <= eidx_ff + 1'b1; state_ff <= S_SCAN;
               end
            end
            S_RELAX: begin
               // keep only a strict improvement
               if (relax_sum < node_rd_ff[16:0]) begin
                  node_mem[to_idx] <= {node_rd_ff[17], relax_sum};
                  pred_mem[to_idx] <= {rd_edge.line, 6'(u_ff)};
               end
               eidx_ff <= eidx_ff + 1'b1; state_ff <= S_SCAN;
            end
            S_WALK: begin
               // pred_rd_ff picks up the predecessor of cur_ff on this edge
               if (cur_ff == 6'(start_ff) || 32'(n_ff) >= MAX_STOPS) begin
                  k_ff <= n_ff; state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_HOP;
               end
            end
            S_HOP: begin
               stack_mem[n_ff[SW-1:0]] <= pred_rd_ff;
               cur_ff <= pred_rd_ff[5:0];
               n_ff <= n_ff + 1'b1;
               state_ff <= S_WALK;
            end
            S_EMIT: begin
               // stack_rd_ff settles on the next entry; drop a taken item
               if (rsp_tready) rsp_tvalid <= 1'b0;
               state_ff <= S_SEND;
            end
            S_SEND: if (!rsp_tvalid || rsp_tready) begin
               rsp_tdata <= stack_rd_ff;
               rsp_tuser <= 1'b1; rsp_tlast <= (k_ff == 1);
               rsp_tvalid <= 1'b1; k_ff <= k_ff - 1'b1;
               state_ff <= (k_ff == 1) ? S_OUT : S_EMIT;
            end
            S_OUT: if (rsp_tready) begin
               rsp_tvalid <= 1'b0; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready with pending result");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EDGES)) else $error("edge count overflow");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> state_ff == S_IDLE)
      else $error("no idle after last");
endmodule
`default_nettype wire

FILE: test/tb_shortest_path_engine.sv
`default_nettype none
module tb_shortest_path_engine;
   import spe_pkg::*;

   localparam int NumStops   = 64;
   localparam int NumEdges   = 256;
   localparam int NoRoute    = 99999;
   localparam int StallLimit = 400000;
   localparam int TailCycles = 200;

   typedef struct {
      logic [5:0] stop;
      logic [9:0] line;
      logic       found;
      logic       last;
   } hop_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // req_type, edge_from, edge_to, edge_minutes,
                                 // edge_line, query_start, query_dest
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;      // path_stop, path_line
   logic        rsp_tuser;      // found
   logic        rsp_tlast;

   // predictor copy of the edge store
   edge_type    edge_mem [NumEdges];
   int          edge_total = 0;

   hop_type     hop_q [$];
   int          err_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;

   shortest_path_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // queue one expected hop
   function automatic void push_hop(logic [5:0] s, logic [9:0] l, logic f, logic t);
      hop_type h;
      h.stop  = s;
      h.line  = l;
      h.found = f;
      h.last  = t;
      hop_q.insert(hop_q.size(), h);
   endfunction

   // route search over the stored edges, ties to the lower stop
   function automatic void predict_route(logic [5:0] s, logic [5:0] d);
      int         cost [NumStops];
      bit         done [NumStops];
      logic [5:0] via_stop [NumStops];
      logic [9:0] via_line [NumStops];
      logic [5:0] chain_stop [$];
      logic [9:0] chain_line [$];
      int         u, ud, sum;
      logic [5:0] cur;
      if (s == d) begin
         push_hop(6'd0, 10'd0, 1'b0, 1'b1);
         return;
      end
      for (int i = 0; i < NumStops; i++) begin
         cost[i] = NoRoute;
         done[i] = 1'b0;
      end
      cost[s] = 0;
      for (int r = 0; r < NumStops; r++) begin
         u  = NumStops;
         ud = NoRoute;
         for (int i = 0; i < NumStops; i++) begin
            if (!done[i] && cost[i] < ud) begin
               ud = cost[i];
               u  = i;
            end
         end
         if (u == NumStops) break;
         done[u] = 1'b1;
         for (int e = 0; e < edge_total; e++) begin
            if (edge_mem[e].from == u) begin
               sum = ud + edge_mem[e].minutes;
               if (sum > NoRoute) sum = NoRoute;
               if (sum < cost[edge_mem[e].to]) begin
                  cost[edge_mem[e].to]     = sum;
                  via_stop[edge_mem[e].to] = 6'(u);
                  via_line[edge_mem[e].to] = edge_mem[e].line;
               end
            end
         end
      end
      if (cost[d] >= NoRoute) begin
         push_hop(6'd0, 10'd0, 1'b0, 1'b1);
         return;
      end
      // walk back from the destination
      chain_stop.push_front(d);
      chain_line.push_front(10'd0);
      cur = d;
      while (cur != s && chain_stop.size() < NumStops) begin
         chain_stop.push_front(via_stop[cur]);
         chain_line.push_front(via_line[cur]);
         cur = via_stop[cur];
      end
      foreach (chain_stop[i])
         push_hop(chain_stop[i], chain_line[i], 1'b1, i == chain_stop.size() - 1);
   endfunction

   // apply one accepted item to the predictor
   function automatic void predict_item(logic [47:0] d);
      req_code_type code;
      edge_type     ed;
      code = req_code_type'(d[1:0]);
      ed   = d[31:2];
      case (code)
         REQ_CLEAR: edge_total = 0;
         REQ_ADD: begin
            if (edge_total < NumEdges) begin
               edge_mem[edge_total] = ed;
               edge_total++;
            end
         end
         REQ_QUERY: predict_route(d[37:32], d[43:38]);
         default: ;
      endcase
   endfunction

   function automatic logic [47:0] pack_item(req_code_type code, logic [5:0] f,
         logic [5:0] t, logic [7:0] m, logic [9:0] l, logic [5:0] s, logic [5:0] d);
      return {4'd0, d, s, l, m, t, f, code};
   endfunction

   // offer one item and wait for it to be taken
   task automatic send_item(logic [47:0] d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(d);
   endtask

   task automatic send_clear();
      send_item(pack_item(REQ_CLEAR, 6'($urandom), 6'($urandom), 8'($urandom),
                          10'($urandom), 6'($urandom), 6'($urandom)));
   endtask

   task automatic send_edge(logic [5:0] f, logic [5:0] t, logic [7:0] m, logic [9:0] l);
      send_item(pack_item(REQ_ADD, f, t, m, l, 6'($urandom), 6'($urandom)));
   endtask

   task automatic send_query(logic [5:0] s, logic [5:0] d);
      send_item(pack_item(REQ_QUERY, 6'($urandom), 6'($urandom), 8'($urandom),
                          10'($urandom), s, d));
   endtask

   // hold the input idle until every hop has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hop_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_clear();
      send_query(6'd0, 6'd1);
      send_query(6'd5, 6'd5);
      send_edge(6'd0, 6'd1, 8'd0, 10'd1);
      send_edge(6'd1, 6'd2, 8'd255, 10'd1023);
      send_edge(6'd0, 6'd2, 8'd255, 10'd512);
      send_edge(6'd2, 6'd63, 8'd170, 10'd682);
      send_edge(6'd63, 6'd62, 8'd85, 10'd341);
      send_item(pack_item(REQ_NONE, 6'd63, 6'd0, 8'd255, 10'd1023, 6'd63, 6'd62));
      send_query(6'd0, 6'd2);
      send_query(6'd0, 6'd63);
      send_query(6'd0, 6'd62);
      send_query(6'd63, 6'd0);
      send_query(6'd1, 6'd63);
      send_clear();
      send_query(6'd0, 6'd63);
      drain();
   endtask

   // fill the store past its size, the overflow edges must be dropped
   task automatic test_store_full();
      send_clear();
      for (int i = 0; i < NumEdges + 3; i++) begin
         if (i < NumEdges - 1)
            send_edge(6'($urandom_range(8, 15)), 6'($urandom_range(8, 15)),
                      8'($urandom), 10'($urandom_range(1, 1023)));
         else
            send_edge(6'd3, 6'd4, 8'd1, 10'd777);
      end
      send_query(6'd3, 6'd4);
      send_query(6'd8, 6'd15);
      drain();
   endtask

   // one small random graph followed by a few queries
   task automatic random_graph();
      int base, span;
      base = ($urandom_range(3) == 0) ? $urandom_range(0, 56) : 0;
      span = ($urandom_range(5) == 0) ? 63 - base : 7;
      send_clear();
      repeat ($urandom_range(3, 14))
         send_edge(6'(base + $urandom_range(span)), 6'(base + $urandom_range(span)),
                   ($urandom_range(7) == 0) ? 8'(255) : 8'($urandom),
                   10'($urandom_range(1, 1023)));
      if ($urandom_range(4) == 0)
         send_item(pack_item(REQ_NONE, 6'($urandom), 6'($urandom), 8'($urandom),
                             10'($urandom), 6'($urandom), 6'($urandom)));
      repeat ($urandom_range(2, 3))
         send_query(6'(base + $urandom_range(span)), 6'(base + $urandom_range(span)));
   endtask

   task automatic test_random();
      int send_pct [4] = '{0, 46, 0, 25};
      int recv_pct [4] = '{0, 0, 46, 25};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         repeat (3) random_graph();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain();
   endtask

   // receiver held off while items are sent, then the input held idle until all hops return
   task automatic test_backpressure();
      hold_cycles = 2000;
      send_clear();
      for (int i = 0; i < 6; i++)
         send_edge(6'(i), 6'(i + 1), 8'($urandom), 10'($urandom_range(1, 1023)));
      send_query(6'd0, 6'd6);
      send_query(6'd1, 6'd5);
      send_query(6'd6, 6'd0);
      drain();
   endtask

   // receiver ready pattern with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each returned hop with the oldest expectation
   always @(posedge clock) begin
      hop_type h;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hop_q.size() == 0) begin
            $display("%0t: unexpected hop stop=%0d line=%0d found=%0b last=%0b", $time,
                     rsp_tdata[5:0], rsp_tdata[15:6], rsp_tuser, rsp_tlast);
            err_count++;
         end else begin
            h = hop_q.pop_front();
            if (rsp_tdata[5:0] !== h.stop || rsp_tdata[15:6] !== h.line ||
                rsp_tuser !== h.found || rsp_tlast !== h.last) begin
               $display("%0t: expected stop=%0d line=%0d found=%0b last=%0b,",
                        $time, h.stop, h.line, h.found, h.last,
                        " got stop=%0d line=%0d found=%0b last=%0b", rsp_tdata[5:0],
                        rsp_tdata[15:6], rsp_tuser, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_store_full();
      test_random();
      test_backpressure();
      repeat (TailCycles) @(posedge clock);
      if (err_count == 0 && hop_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: shortest_path_engine.f
sv/spe_pkg.sv
sv/spe_edge_mem.sv
sv/shortest_path_engine.sv
test/tb_shortest_path_engine.sv
